// ===== hw/rtl/dbtu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbtu_pkg
// Shared types and constants of the debug breakpoint and opcode trap unit.
// ---------------------------------------------------------------------------
package dbtu_pkg;

   localparam int NUM_BREAKPOINTS = 16;
   localparam int BP_IDX_W        = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;
   localparam int BP_CNT_W        = $clog2(NUM_BREAKPOINTS + 1);
   localparam int TRAP_DEPTH      = 256;
   localparam int ADDR_W          = 16;
   localparam int OPCODE_W        = 8;
   localparam int STEP_CLK_W      = 4;
   localparam int CLOCK_W         = 32;
   localparam int COUNT_OUT_W     = 5;

   typedef enum logic [2:0] {
      KIND_STEP       = 3'd0,
      KIND_ADD_BP     = 3'd1,
      KIND_REMOVE_BP  = 3'd2,
      KIND_CLEAR_BPS  = 3'd3,
      KIND_SET_TRAP   = 3'd4,
      KIND_CLR_TRAP   = 3'd5,
      KIND_CLR_TRAPS  = 3'd6,
      KIND_ZERO_CLK   = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       address;
      logic [OPCODE_W-1:0]     opcode;
      logic [STEP_CLK_W-1:0]   step_clocks;
   } req_type;

   typedef struct packed {
      logic                    halt;
      logic                    status;
      logic [COUNT_OUT_W-1:0]  bp_count_out;
      logic [CLOCK_W-1:0]      clock_total_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MATCH = 2'd1,
      ST_EXEC  = 2'd2
   } state_type;

   typedef struct packed {
      logic load_req;
      logic load_match;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic rsp_stall;
   } stat_type;

endpackage

// ===== hw/rtl/dbtu_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbtu_ctrl
// Sequencer: capture a request, run the match cycle, commit and respond.
// ---------------------------------------------------------------------------
module dbtu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dbtu_pkg::stat_type stat,
   output dbtu_pkg::cmd_type  cmd
);

   dbtu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbtu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load_req   = 1'b0;
      cmd.load_match = 1'b0;
      cmd.execute    = 1'b0;
      case (state_ff)
         dbtu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = dbtu_pkg::ST_MATCH;
            end
         end
         dbtu_pkg::ST_MATCH: begin
            cmd.load_match = 1'b1;
            state_in       = dbtu_pkg::ST_EXEC;
         end
         dbtu_pkg::ST_EXEC: begin
            // hold until the output register can take the response
            if (!stat.rsp_stall) begin
               cmd.execute = 1'b1;
               state_in    = dbtu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dbtu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/dbtu_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbtu_datapath
// Breakpoint list, trap map, clock count and the response register.
// ---------------------------------------------------------------------------
module dbtu_datapath (
   input  logic               clock,
   input  logic               reset,
   input  dbtu_pkg::cmd_type  cmd,
   output dbtu_pkg::stat_type stat,
   input  dbtu_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dbtu_pkg::rsp_type  rsp_data
);

   localparam int N = dbtu_pkg::NUM_BREAKPOINTS;

   dbtu_pkg::req_type                 req_ff;
   logic [N-1:0]                      match_ff, match_in;
   logic                              trap_hit_ff;
   logic [dbtu_pkg::ADDR_W-1:0]       bp_addr_ff [N];
   logic [dbtu_pkg::ADDR_W-1:0]       bp_shift_src [N];
   logic [N-1:0]                      shift_sel;
   logic [dbtu_pkg::BP_CNT_W-1:0]     bp_count_ff, bp_count_in;
   logic [dbtu_pkg::TRAP_DEPTH-1:0]   trap_ff, trap_in;
   logic [dbtu_pkg::CLOCK_W-1:0]      clock_ff, clock_in;
   dbtu_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              hit;
   logic                              bp_add_en;
   logic                              bp_remove_en;

   // compare against every held entry in parallel
   always_comb begin
      for (int j = 0; j < N; j++) begin
         match_in[j] = (bp_addr_ff[j] == req_ff.address) &&
                       (dbtu_pkg::BP_CNT_W'(j) < bp_count_ff);
      end
   end

   // entries at and above the first match move down one place
   always_comb begin
      logic run;
      run = 1'b0;
      for (int j = 0; j < N; j++) begin
         run          = run | match_ff[j];
         shift_sel[j] = run;
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_shift
         if (g < N - 1) begin : g_mid
            assign bp_shift_src[g] = bp_addr_ff[g+1];
         end else begin : g_top
            assign bp_shift_src[g] = bp_addr_ff[g];
         end
      end
   endgenerate

   assign hit = |match_ff;

   always_comb begin
      bp_count_in  = bp_count_ff;
      trap_in      = trap_ff;
      clock_in     = clock_ff;
      bp_add_en    = 1'b0;
      bp_remove_en = 1'b0;
      rsp_in       = '0;
      case (req_ff.kind)
         dbtu_pkg::KIND_STEP: begin
            clock_in    = clock_ff + dbtu_pkg::CLOCK_W'(req_ff.step_clocks);
            rsp_in.halt = hit | trap_hit_ff;
         end
         dbtu_pkg::KIND_ADD_BP: begin
            if (!hit) begin
               if (bp_count_ff < dbtu_pkg::BP_CNT_W'(N)) begin
                  bp_add_en   = 1'b1;
                  bp_count_in = bp_count_ff + 1'b1;
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
         end
         dbtu_pkg::KIND_REMOVE_BP: begin
            if (hit) begin
               bp_remove_en = 1'b1;
               bp_count_in  = bp_count_ff - 1'b1;
            end
         end
         dbtu_pkg::KIND_CLEAR_BPS: begin
            bp_count_in = '0;
         end
         dbtu_pkg::KIND_SET_TRAP: begin
            trap_in[req_ff.opcode] = 1'b1;
         end
         dbtu_pkg::KIND_CLR_TRAP: begin
            trap_in[req_ff.opcode] = 1'b0;
         end
         dbtu_pkg::KIND_CLR_TRAPS: begin
            trap_in = '0;
         end
         dbtu_pkg::KIND_ZERO_CLK: begin
            clock_in = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.bp_count_out    = dbtu_pkg::COUNT_OUT_W'(bp_count_in);
      rsp_in.clock_total_out = clock_in;
   end

   assign rsp_valid_in   = cmd.execute | (rsp_valid_ff & ~rsp_ready);
   assign stat.rsp_stall = rsp_valid_ff & ~rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_count_ff  <= '0;
         trap_ff      <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            bp_count_ff <= bp_count_in;
            trap_ff     <= trap_in;
            clock_ff    <= clock_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_match) begin
         match_ff    <= match_in;
         trap_hit_ff <= trap_ff[req_ff.opcode];
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // breakpoint entries: no reset, only entries below the count are read
   always_ff @(posedge clock) begin
      for (int j = 0; j < N; j++) begin
         if (cmd.execute && bp_add_en &&
             (dbtu_pkg::BP_IDX_W'(j) == bp_count_ff[dbtu_pkg::BP_IDX_W-1:0])) begin
            bp_addr_ff[j] <= req_ff.address;
         end else if (cmd.execute && bp_remove_en && shift_sel[j]) begin
            bp_addr_ff[j] <= bp_shift_src[j];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/debug_breakpoint_trap_unit_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// debug_breakpoint_trap_unit_top
// Debug halt unit: breakpoint list, opcode trap map and a wrapping clock
// count, driven by step events and maintenance commands.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Ports                          Payload
//   req       in         req_valid, req_ready, req_data dbtu_pkg::req_type
//   rsp       out        rsp_valid, rsp_ready, rsp_data dbtu_pkg::rsp_type
//
// Each request goes through capture, a parallel compare against all
// held breakpoints plus the trap map read, then commit and load the response.
// One request is in work at a time; the next is accepted while the previous
// response still waits in the output register.
// A stalled response holds the commit cycle until the output register frees.
// Reset clears the count, the trap map, the clock total and all control;
// breakpoint entries need no clearing since only those below the count are read.
// ---------------------------------------------------------------------------
module debug_breakpoint_trap_unit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dbtu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dbtu_pkg::rsp_type rsp_data
);

   // commands from the sequencer, status back from the datapath
   dbtu_pkg::cmd_type  cmd;
   dbtu_pkg::stat_type stat;

   dbtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // list, trap map, clock count and response register
   dbtu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
